>>> hdl/lt_pkg.sv
// Types, character codes and classification functions shared by the tokenizer modules.
package lt_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_BLOCK  = 2'd1,
        MODE_LINE   = 2'd2,
        MODE_STRING = 2'd3
    } lex_mode_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;

    // one emitted token character
    typedef struct packed {
        logic [7:0] out_char;
        logic       token_start;
    } res_t;

    // all results caused by one request
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic held_valid;
        logic skip_pending;
    } fe_stat_t;

    // outcome of examining one character
    typedef struct packed {
        logic      emit;
        logic      start;
        lex_mode_t mode;
        logic      tok;
        logic      consumed;
    } ex_t;

    function automatic logic is_op(input logic [7:0] c);
        logic r;
        case (c)
            8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h23, 8'h28, 8'h29, 8'h3F,
            8'h2E, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h5E, 8'h26,
            8'h7C, 8'h7E, 8'h21, 8'h3D, 8'h3C, 8'h3E: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // c with lookahead nx (CH_NUL when none)
    function automatic ex_t examine(input lex_mode_t mode, input logic tok,
                                    input logic [7:0] c, input logic [7:0] nx);
        ex_t r;
        r.emit     = 1'b0;
        r.start    = 1'b0;
        r.mode     = mode;
        r.tok      = tok;
        r.consumed = 1'b0;
        unique case (mode)
            MODE_NORMAL: begin
                if (c == CH_SLASH && (nx == CH_STAR || nx == CH_SLASH)) begin
                    r.tok      = 1'b0;
                    r.emit     = 1'b1;
                    r.start    = 1'b1;
                    r.mode     = (nx == CH_STAR) ? MODE_BLOCK : MODE_LINE;
                    r.consumed = 1'b1;
                end else if (c == CH_QUOTE) begin
                    r.emit  = 1'b1;
                    r.start = !tok;
                    r.tok   = 1'b1;
                    r.mode  = MODE_STRING;
                end else if (is_op(c)) begin
                    r.tok      = 1'b0;
                    r.emit     = 1'b1;
                    r.start    = 1'b1;
                    r.consumed = (c == CH_HASH && nx == CH_HASH) ||
                                 (c == CH_LT && nx == CH_COLON);
                end else if (is_space(c)) begin
                    r.tok = 1'b0;
                end else begin
                    r.emit  = 1'b1;
                    r.start = !tok;
                    r.tok   = 1'b1;
                end
            end
            MODE_BLOCK: begin
                if (c == CH_STAR && nx == CH_SLASH) begin
                    r.emit     = 1'b1;
                    r.start    = 1'b1;
                    r.mode     = MODE_NORMAL;
                    r.tok      = 1'b0;
                    r.consumed = 1'b1;
                end
            end
            MODE_LINE: begin
                if (c == CH_LF) begin
                    r.mode = MODE_NORMAL;
                end
            end
            MODE_STRING: begin
                r.emit = 1'b1;
                if (c == CH_QUOTE) begin
                    r.mode = MODE_NORMAL;
                    r.tok  = 1'b0;
                end
            end
            default: r.mode = MODE_NORMAL;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/lt_front.sv
// Front end: lookahead register, lexer state and classification of each request.
module lt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_ch,
    input  logic              s_end_of_line,
    input  lt_pkg::q_stat_t   q_stat,
    output logic              push,
    output lt_pkg::q_entry_t  push_entry,
    output lt_pkg::fe_stat_t  fe_stat
);

    lt_pkg::lex_mode_t mode_reg, mode_next;
    logic [7:0]        held_char_reg, held_char_next;
    logic              held_valid_reg, held_valid_next;
    logic              skip_reg, skip_next;
    logic              tok_reg, tok_next;

    lt_pkg::ex_t       ex1, ex2;
    lt_pkg::lex_mode_t mode_a;
    logic              tok_a, consumed;
    logic              a_emit, a_start, b_emit, b_start;
    lt_pkg::res_t      res_a, res_b;
    logic              accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        ex1      = lt_pkg::examine(mode_reg, tok_reg, held_char_reg, s_ch);
        a_emit   = 1'b0;
        a_start  = 1'b0;
        mode_a   = mode_reg;
        tok_a    = tok_reg;
        consumed = 1'b0;
        if (held_valid_reg) begin
            if (skip_reg) begin
                // second half of an already joined pair
                a_emit = 1'b1;
            end else begin
                a_emit   = ex1.emit;
                a_start  = ex1.start;
                mode_a   = ex1.mode;
                tok_a    = ex1.tok;
                consumed = ex1.consumed;
            end
        end

        // last character of a line is examined with no lookahead
        ex2     = lt_pkg::examine(mode_a, tok_a, s_ch, lt_pkg::CH_NUL);
        b_emit  = 1'b0;
        b_start = 1'b0;
        if (consumed) begin
            b_emit = s_end_of_line;
        end else if (s_end_of_line) begin
            b_emit  = ex2.emit;
            b_start = ex2.start;
        end

        res_a.out_char    = held_char_reg;
        res_a.token_start = a_start;
        res_b.out_char    = s_ch;
        res_b.token_start = b_start;

        push_entry.two = a_emit && b_emit;
        push_entry.r0  = a_emit ? res_a : res_b;
        push_entry.r1  = res_b;
        push           = accept && (a_emit || b_emit);

        mode_next       = mode_reg;
        tok_next        = tok_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        skip_next       = skip_reg;
        if (accept) begin
            if (s_end_of_line) begin
                mode_next       = lt_pkg::MODE_NORMAL;
                tok_next        = 1'b0;
                held_char_next  = lt_pkg::CH_NUL;
                held_valid_next = 1'b0;
                skip_next       = 1'b0;
            end else begin
                mode_next       = mode_a;
                tok_next        = tok_a;
                held_char_next  = s_ch;
                held_valid_next = 1'b1;
                skip_next       = consumed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= lt_pkg::MODE_NORMAL;
            tok_reg        <= 1'b0;
            held_char_reg  <= lt_pkg::CH_NUL;
            held_valid_reg <= 1'b0;
            skip_reg       <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            tok_reg        <= tok_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            skip_reg       <= skip_next;
        end
    end

    assign fe_stat.held_valid   = held_valid_reg;
    assign fe_stat.skip_pending = skip_reg;

endmodule

>>> hdl/lt_queue.sv
// Short FIFO of per-request result groups between front and back end.
module lt_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lt_pkg::q_entry_t  push_entry,
    input  logic              pop,
    output lt_pkg::q_entry_t  head,
    output logic              head_valid,
    output lt_pkg::q_stat_t   q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lt_pkg::q_entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_valid   = !q_stat.empty;
    assign head         = mem_reg[rd_ptr_reg];
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hdl/lt_back.sv
// Back end: serializes each result group into the registered output channel.
module lt_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  lt_pkg::q_entry_t  head,
    input  logic              head_valid,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_char,
    output logic              m_token_start,
    output logic              m_last
);

    logic         m_valid_reg, m_valid_next;
    logic [7:0]   out_char_reg, out_char_next;
    logic         start_reg, start_next;
    logic         last_reg, last_next;
    logic         phase_reg, phase_next;
    logic         load, sel_last;
    lt_pkg::res_t sel;

    always_comb begin
        load     = head_valid && (!m_valid_reg || m_ready);
        sel      = phase_reg ? head.r1 : head.r0;
        sel_last = phase_reg || !head.two;
        pop      = load && sel_last;

        m_valid_next  = m_valid_reg && !m_ready;
        out_char_next = out_char_reg;
        start_next    = start_reg;
        last_next     = last_reg;
        phase_next    = phase_reg;
        if (load) begin
            m_valid_next  = 1'b1;
            out_char_next = sel.out_char;
            start_next    = sel.token_start;
            last_next     = sel_last;
            phase_next    = !sel_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_char_reg <= out_char_next;
        start_reg    <= start_next;
        last_reg     <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_char    = out_char_reg;
    assign m_token_start = start_reg;
    assign m_last        = last_reg;

endmodule

>>> hdl/line_tokenizer_with_comments_core.sv
// Top level of the streaming line tokenizer with comment and string handling.
//
// Input channel (s_*): one character per request, s_end_of_line on the last
// character of a line. Output channel (m_*): token characters, m_token_start
// on the first character of each token, m_last on the final result of the
// request that caused it (a request gives zero, one or two results).
// One character is held back as lookahead, so a character's results mostly
// come out with the request of the next character; the end of a line flushes.
// Results of an accepted request are written into the queue, then loaded into
// the output register of the back end, from which they appear on m_*.
// Throughput: one request per cycle while the output drains one result per
// cycle; a request with two results is serialized through the single output
// register of the back end, one result after the other.
// The queue of QUEUE_DEPTH result groups decouples both sides; s_ready falls
// only when it is full, so a stalled receiver stops input once QUEUE_DEPTH
// result groups wait behind the one in the output register.
// Reset clears lexer state, queue and output.
module line_tokenizer_with_comments_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_end_of_line,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_token_start,
    output logic       m_last
);

    logic             push, pop, head_valid;
    lt_pkg::q_entry_t push_entry, head;
    lt_pkg::q_stat_t  q_stat;
    lt_pkg::fe_stat_t fe_stat;

    lt_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_end_of_line (s_end_of_line),
        .q_stat        (q_stat),
        .push          (push),
        .push_entry    (push_entry),
        .fe_stat       (fe_stat)
    );

    lt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .q_stat     (q_stat)
    );

    lt_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_token_start (m_token_start),
        .m_last        (m_last)
    );

    // output is empty after reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // end of line drops the lookahead
    a_eol_flushes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_end_of_line |=> !fe_stat.held_valid)
        else $error("lookahead kept across end of line");

    a_skip_needs_held: assert property (@(posedge aclk) disable iff (!aresetn)
        fe_stat.skip_pending |-> fe_stat.held_valid)
        else $error("pair continuation without held character");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !s_ready && !q_stat.empty)
        else $error("input accepted with queue full");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the streaming line tokenizer core.
`timescale 1ns / 100ps

module tb_top;

    localparam int ITEM_TARGET  = 1300;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;

    typedef struct packed {
        logic [7:0] out_char;
        logic       token_start;
        logic       is_last;
    } tok_char_t;

    // Tracks the lexer state of the line and the token characters still owed.
    class token_tracker;
        lt_pkg::lex_mode_t mode;
        logic [7:0] held_char;
        bit         held_ok;
        bit         skip_next;
        bit         word_open;
        tok_char_t  step_out[$];
        tok_char_t  chars_due[$];
        int         errors;

        function new();
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            mode      = lt_pkg::MODE_NORMAL;
            held_char = lt_pkg::CH_NUL;
            held_ok   = 1'b0;
            skip_next = 1'b0;
            word_open = 1'b0;
        endfunction

        function bit op_char(logic [7:0] c);
            string ops;
            ops = "{}[]#()?.+-*/%^&|~!=<>";
            foreach (ops[i]) begin
                if (ops[i] == c) return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit space_char(logic [7:0] c);
            return (c == lt_pkg::CH_SPACE) || (c >= lt_pkg::CH_TAB && c <= lt_pkg::CH_CR);
        endfunction

        function void put(logic [7:0] c, bit start);
            tok_char_t t;
            t = '{c, start, 1'b0};
            if (step_out.size() < 2) step_out.insert(step_out.size(), t);
        endfunction

        // returns 1 when c and nx pair up and nx is taken as continuation
        function bit scan(logic [7:0] c, logic [7:0] nx);
            case (mode)
                lt_pkg::MODE_NORMAL: begin
                    if (c == lt_pkg::CH_SLASH &&
                        (nx == lt_pkg::CH_STAR || nx == lt_pkg::CH_SLASH)) begin
                        word_open = 1'b0;
                        put(c, 1'b1);
                        mode = (nx == lt_pkg::CH_STAR) ? lt_pkg::MODE_BLOCK
                                                       : lt_pkg::MODE_LINE;
                        return 1'b1;
                    end
                    if (c == lt_pkg::CH_QUOTE) begin
                        put(c, !word_open);
                        word_open = 1'b1;
                        mode = lt_pkg::MODE_STRING;
                        return 1'b0;
                    end
                    if (op_char(c)) begin
                        word_open = 1'b0;
                        put(c, 1'b1);
                        return (c == lt_pkg::CH_HASH && nx == lt_pkg::CH_HASH) ||
                               (c == lt_pkg::CH_LT && nx == lt_pkg::CH_COLON);
                    end
                    if (space_char(c)) begin
                        word_open = 1'b0;
                        return 1'b0;
                    end
                    put(c, !word_open);
                    word_open = 1'b1;
                    return 1'b0;
                end
                lt_pkg::MODE_BLOCK: begin
                    if (c == lt_pkg::CH_STAR && nx == lt_pkg::CH_SLASH) begin
                        put(c, 1'b1);
                        mode = lt_pkg::MODE_NORMAL;
                        word_open = 1'b0;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                lt_pkg::MODE_LINE: begin
                    if (c == lt_pkg::CH_LF) mode = lt_pkg::MODE_NORMAL;
                    return 1'b0;
                end
                default: begin
                    put(c, 1'b0);
                    if (c == lt_pkg::CH_QUOTE) begin
                        mode = lt_pkg::MODE_NORMAL;
                        word_open = 1'b0;
                    end
                    return 1'b0;
                end
            endcase
        endfunction

        function void note_char(logic [7:0] c, bit eol);
            bit paired;
            paired = 1'b0;
            step_out.delete();
            if (held_ok) begin
                if (skip_next) begin
                    put(held_char, 1'b0);
                end else if (scan(held_char, c)) begin
                    if (eol) put(c, 1'b0);
                    paired = 1'b1;
                end
                held_ok   = 1'b0;
                skip_next = 1'b0;
            end
            if (paired) begin
                if (!eol) begin
                    held_char = c;
                    held_ok   = 1'b1;
                    skip_next = 1'b1;
                end
            end else if (eol) begin
                void'(scan(c, lt_pkg::CH_NUL));
            end else begin
                held_char = c;
                held_ok   = 1'b1;
            end
            if (eol) clear_line();
            if (step_out.size() > 0) step_out[step_out.size() - 1].is_last = 1'b1;
            foreach (step_out[i]) chars_due.insert(chars_due.size(), step_out[i]);
        endfunction

        function void check_char(logic [7:0] c, logic start, logic lst);
            tok_char_t want;
            if (chars_due.size() == 0) begin
                $error("unexpected token char: out_char %h token_start %b last %b",
                       c, start, lst);
                errors++;
                return;
            end
            want = chars_due.pop_front();
            if (want.out_char !== c) begin
                $error("out_char: expected %h, actual %h", want.out_char, c);
                errors++;
            end
            if (want.token_start !== start) begin
                $error("token_start: expected %b, actual %b", want.token_start, start);
                errors++;
            end
            if (want.is_last !== lst) begin
                $error("last: expected %b, actual %b", want.is_last, lst);
                errors++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_ch;
    logic       s_end_of_line;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_char;
    logic       m_token_start;
    logic       m_last;

    token_tracker tracker;
    bit           burst;
    bit           hold_request;

    line_tokenizer_with_comments_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_end_of_line (s_end_of_line),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_token_start (m_token_start),
        .m_last        (m_last)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Called at a rising edge; returns at the edge that accepts the request.
    task automatic send_char(input logic [7:0] c, input bit eol);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_ch          <= c;
        s_end_of_line <= eol;
        do @(negedge aclk); while (!s_ready);
        tracker.note_char(c, eol);
        @(posedge aclk);
    endtask

    task automatic send_line(input string s);
        foreach (s[i]) send_char(s[i], i == s.len() - 1);
    endtask

    // Mostly C-like text, with the pair and comment characters weighted up.
    function automatic logic [7:0] pick_char();
        int    r;
        string ops;
        ops = "{}[]#()?.+-*/%^&|~!=<>";
        r = $urandom_range(0, 99);
        if (r < 30) return 8'(32'h61 + $urandom_range(0, 25));
        if (r < 38) return 8'(32'h30 + $urandom_range(0, 9));
        if (r < 50) return ($urandom_range(0, 1) == 0) ? lt_pkg::CH_SPACE
                                                        : 8'(9 + $urandom_range(0, 4));
        if (r < 70) return ops[$urandom_range(0, ops.len() - 1)];
        if (r < 76) return lt_pkg::CH_QUOTE;
        if (r < 83) return lt_pkg::CH_SLASH;
        if (r < 88) return lt_pkg::CH_STAR;
        if (r < 92) return lt_pkg::CH_HASH;
        if (r < 95) return lt_pkg::CH_COLON;
        if (r < 97) return lt_pkg::CH_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    // receiver: random hold-off per result, one long hold on request
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 4);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (!m_valid);
            @(posedge aclk);
        end
    end

    // outputs are stable at the falling edge; a handshake seen here
    // completes at the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_char(m_out_char, m_token_start, m_last);
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(negedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int   sent;
        int   line_no;
        int   line_len;
        bit   noise;
        bit   hold_done;
        logic [7:0] c;

        tracker       = new();
        sent          = 0;
        line_no       = 0;
        hold_done     = 1'b0;
        burst         = 1'b0;
        hold_request  = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_ch          = lt_pkg::CH_NUL;
        s_end_of_line = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // extreme codes are word characters
        send_char(lt_pkg::CH_NUL, 1'b0);
        send_char(8'hFF, 1'b1);
        send_line("a/*b*/c");       // comment mark right after a word
        send_line("# ##<:");        // lone hash, joined pairs
        send_line("w\"s t");        // quote joins word, string open at end of line
        send_line("//\nq");         // line feed ends a line comment
        send_line("\t<");           // no lookahead for the last character

        while (sent < ITEM_TARGET) begin
            line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40)
                                                   : $urandom_range(1, 16);
            noise = ($urandom_range(0, 9) == 0);
            burst = (line_no % 5 == 4);
            if (!hold_done && sent >= ITEM_TARGET / 2) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            for (int i = 0; i < line_len; i++) begin
                c = noise ? 8'($urandom_range(0, 255)) : pick_char();
                send_char(c, i == line_len - 1);
                sent++;
            end
            line_no++;
        end
        s_valid <= 1'b0;
        burst   = 1'b0;

        while (tracker.chars_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> line_tokenizer_with_comments_core.f
hdl/lt_pkg.sv
hdl/lt_front.sv
hdl/lt_queue.sv
hdl/lt_back.sv
hdl/line_tokenizer_with_comments_core.sv
tb/tb_top.sv
